### hdl/mpm_pkg.sv
// shared widths and types for the modular 2x2 matrix power block
package mpm_pkg;

   localparam int ENTRY_BITS   = 16;
   localparam int EXP_BITS     = 31;
   localparam int PROD_BITS    = 2 * ENTRY_BITS;
   localparam int SUM_BITS     = PROD_BITS + 1;
   localparam int RED_CNT_BITS = $clog2(SUM_BITS + 1);

   typedef logic [ENTRY_BITS-1:0] entry_type;
   typedef logic [ENTRY_BITS:0]   modext_type;
   typedef logic [EXP_BITS-1:0]   exp_type;
   typedef logic [PROD_BITS-1:0]  prod_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef entry_type [3:0]       mat_type;

endpackage

### hdl/mpm_modred.sv
// bit-serial restoring reduction of a sum of products by the modulus
module mpm_modred (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mpm_pkg::sum_type   value,
   input  mpm_pkg::entry_type modulus,
   output logic               done,
   output mpm_pkg::entry_type remainder
);
   import mpm_pkg::*;

   modext_type              rem_ff, rem_in;
   modext_type              mod_ff, mod_in;
   sum_type                 val_ff, val_in;
   logic [RED_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [ENTRY_BITS+1:0]   trial;
   logic [ENTRY_BITS+1:0]   trial_sub;
   logic                    trial_ge;

   assign trial     = {rem_ff, val_ff[SUM_BITS-1]};
   assign trial_ge  = trial >= {1'b0, mod_ff};
   assign trial_sub = trial - {1'b0, mod_ff};

   always_comb begin
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      val_in  = val_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         val_in  = value;
         // zero modulus stands for two to the entry width
         mod_in  = (modulus == '0) ? {1'b1, {ENTRY_BITS{1'b0}}} : {1'b0, modulus};
         cnt_in  = RED_CNT_BITS'(SUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[ENTRY_BITS:0] : trial[ENTRY_BITS:0];
         val_in = {val_ff[SUM_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - RED_CNT_BITS'(1);
         if (cnt_ff == RED_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      mod_ff <= mod_in;
      val_ff <= val_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[ENTRY_BITS-1:0];

endmodule

### hdl/matrix_power_mod_2x2.sv
// modular 2x2 matrix power by square-and-multiply on one multiplier and one reducer
// zero exponent: the identity goes straight to ST_FINISH, which raises rsp_valid once
// any earlier response is taken; otherwise the input entries are reduced first, then
// each result entry takes two products, their sum and one reduction, with up to
// 2*bitlength(exponent)-1 matrix products; the bit-serial reducer sets the pace
// req_ready is high only while idle; synchronous reset clears sequencer and rsp_valid
module matrix_power_mod_2x2 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mpm_pkg::entry_type req_entry_00,
   input  mpm_pkg::entry_type req_entry_01,
   input  mpm_pkg::entry_type req_entry_10,
   input  mpm_pkg::entry_type req_entry_11,
   input  mpm_pkg::exp_type   req_exponent,
   input  mpm_pkg::entry_type req_modulus,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mpm_pkg::entry_type rsp_power_00,
   output mpm_pkg::entry_type rsp_power_01,
   output mpm_pkg::entry_type rsp_power_10,
   output mpm_pkg::entry_type rsp_power_11
);
   import mpm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_PREP_WAIT,
      ST_STEP,
      ST_MUL0,
      ST_MUL1,
      ST_ADD,
      ST_RED,
      ST_RED_WAIT,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   mat_type    raw_ff, raw_in;
   mat_type    base_ff, base_in;
   mat_type    acc_ff, acc_in;
   mat_type    res_ff, res_in;
   mat_type    out_ff, out_in;
   exp_type    n_ff, n_in;
   entry_type  mod_ff, mod_in;
   logic [1:0] k_ff, k_in;
   logic       sq_ff, sq_in;
   prod_type   prod_ff, prod_in;
   sum_type    sum_ff, sum_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       red_start;
   logic       red_done;
   entry_type  red_rem;
   logic       term;
   mat_type    opa_mat;
   entry_type  opa;
   entry_type  opb;
   prod_type   product;
   entry_type  one_red;
   mat_type    res_full;

   mpm_modred u_modred (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .value     (sum_ff),
      .modulus   (mod_ff),
      .done      (red_done),
      .remainder (red_rem)
   );

   assign red_start = (state_ff == ST_PREP) || (state_ff == ST_RED);
   assign term      = (state_ff == ST_MUL1);
   assign opa_mat   = sq_ff ? base_ff : acc_ff;
   assign opa       = opa_mat[{k_ff[1], term}];
   assign opb       = base_ff[{term, k_ff[0]}];
   assign product   = PROD_BITS'(opa) * PROD_BITS'(opb);
   assign one_red   = (mod_ff == ENTRY_BITS'(1)) ? '0 : ENTRY_BITS'(1);

   always_comb begin
      res_full          = res_ff;
      res_full[2'd3]    = red_rem;
   end

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      n_in         = n_ff;
      mod_in       = mod_ff;
      k_in         = k_ff;
      sq_in        = sq_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               raw_in = {req_entry_11, req_entry_10, req_entry_01, req_entry_00};
               n_in   = req_exponent;
               mod_in = req_modulus;
               k_in   = 2'd0;
               sum_in = SUM_BITS'(req_entry_00);
               if (req_exponent == '0) begin
                  // identity, left unreduced
                  acc_in   = {ENTRY_BITS'(1), ENTRY_BITS'(0), ENTRY_BITS'(0), ENTRY_BITS'(1)};
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            state_in = ST_PREP_WAIT;
         end
         ST_PREP_WAIT: begin
            if (red_done) begin
               base_in[k_ff] = red_rem;
               if (k_ff == 2'd3) begin
                  acc_in   = {one_red, ENTRY_BITS'(0), ENTRY_BITS'(0), one_red};
                  state_in = ST_STEP;
               end else begin
                  k_in     = k_ff + 2'd1;
                  sum_in   = SUM_BITS'(raw_ff[k_ff + 2'd1]);
                  state_in = ST_PREP;
               end
            end
         end
         ST_STEP: begin
            k_in = 2'd0;
            if (n_ff[0]) begin
               sq_in    = 1'b0;
               state_in = ST_MUL0;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            n_in = n_ff >> 1;
            if ((n_ff >> 1) != '0) begin
               sq_in    = 1'b1;
               k_in     = 2'd0;
               state_in = ST_MUL0;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL0: begin
            prod_in  = product;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            sum_in   = SUM_BITS'(prod_ff);
            prod_in  = product;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in   = sum_ff + SUM_BITS'(prod_ff);
            state_in = ST_RED;
         end
         ST_RED: begin
            state_in = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            if (red_done) begin
               res_in[k_ff] = red_rem;
               if (k_ff == 2'd3) begin
                  if (sq_ff) begin
                     base_in  = res_full;
                     state_in = ST_STEP;
                  end else begin
                     acc_in   = res_full;
                     state_in = ST_SHIFT;
                  end
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_MUL0;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
      n_ff    <= n_in;
      mod_ff  <= mod_in;
      k_ff    <= k_in;
      sq_ff   <= sq_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_power_00 = out_ff[2'd0];
   assign rsp_power_01 = out_ff[2'd1];
   assign rsp_power_10 = out_ff[2'd2];
   assign rsp_power_11 = out_ff[2'd3];

endmodule
